/* rtl/rclp_pkg.sv */
// shared types and constants of the rotator command line parser
`default_nettype none

package rclp_pkg;

  typedef enum logic [1:0] {
    ACT_SET_AZ = 2'd0,
    ACT_SET_EL = 2'd1,
    ACT_REPORT = 2'd2
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] az;
    logic [15:0] el;
    logic        last;
  } result_t;

  // up to two results per received byte
  typedef struct packed {
    logic [1:0]         cnt;
    result_t [1:0]      res;
  } core_out_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef struct packed {
    logic             room;
    logic [QCntW-1:0] count;
  } q_status_t;

endpackage

`default_nettype wire

/* rtl/rclp_core.sv */
// line parse state and per-byte result generation
`default_nettype none

module rclp_core #(
  parameter int unsigned LINE_CHARS = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic [15:0]         az_i,
  input  wire logic [15:0]         el_i,
  output rclp_pkg::core_out_t      out_o
);

  localparam int unsigned CW = $clog2(LINE_CHARS);
  localparam logic [CW-1:0] LAST = CW'(LINE_CHARS - 1);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [14:0] ACC_CAP   = 15'd16384;
  localparam logic [15:0] VALUE_MAX = 16'd32767;

  localparam logic [1:0] TOK_FIRST  = 2'd0;
  localparam logic [1:0] TOK_GAP    = 2'd1;
  localparam logic [1:0] TOK_SECOND = 2'd2;
  localparam logic [1:0] TOK_DONE   = 2'd3;

  typedef enum logic [7:0] {
    CLS_UNDECIDED = 8'b0000_0001,
    CLS_SAW_A     = 8'b0000_0010,
    CLS_SAW_E     = 8'b0000_0100,
    CLS_AZ        = 8'b0000_1000,
    CLS_EL        = 8'b0001_0000,
    CLS_NONE      = 8'b0010_0000,
    CLS_AZ_SPACE  = 8'b0100_0000,
    CLS_REPORT    = 8'b1000_0000
  } cls_e;

  typedef struct packed {
    logic        anum;
    logic        sp;
    logic        fds;
    logic        hb;
    logic [14:0] acc;
  } num_t;

  localparam num_t NUM_CLEAR = '{anum: 1'b1, sp: 1'b0, fds: 1'b0, hb: 1'b0, acc: '0};

  function automatic num_t feed_num(num_t s, logic [7:0] c);
    num_t        r;
    logic [18:0] a;
    logic [3:0]  d;
    r = s;
    d = c[3:0];
    a = 19'(s.acc) * 19'd10 + 19'(d);
    if (c inside {[CH_0:CH_9]}) begin
      if (!s.sp) begin
        r.acc = (a > 19'(ACC_CAP)) ? ACC_CAP : a[14:0];
      end else if (!s.fds) begin
        r.fds = 1'b1;
        r.hb  = (d >= 4'd5);
      end
    end else if (c == CH_DOT) begin
      if (!s.sp) r.sp = 1'b1;
      else       r.fds = 1'b1;
    end else begin
      r.anum = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [15:0] num_value(num_t s);
    logic [15:0] v;
    v = {s.acc, s.hb};
    return (v > VALUE_MAX) ? VALUE_MAX : v;
  endfunction

  logic [CW-1:0] cc_q, cc_d;
  cls_e          cls_q, cls_d;
  logic [1:0]    tn_q, tn_d;
  logic [1:0]    tp_q, tp_d;
  logic          pok_q, pok_d;
  num_t          num_q, num_d;
  logic [15:0]   azt_q, azt_d;
  logic          aztv_q, aztv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= '0;
      cls_q  <= CLS_UNDECIDED;
      tn_q   <= TOK_FIRST;
      tp_q   <= '0;
      pok_q  <= 1'b0;
      num_q  <= NUM_CLEAR;
      azt_q  <= '0;
      aztv_q <= 1'b0;
    end else if (fire_i) begin
      cc_q   <= cc_d;
      cls_q  <= cls_d;
      tn_q   <= tn_d;
      tp_q   <= tp_d;
      pok_q  <= pok_d;
      num_q  <= num_d;
      azt_q  <= azt_d;
      aztv_q <= aztv_d;
    end
  end

  // state update
  always_comb begin
    logic          sp;
    logic          az_line;
    logic [1:0]    tn;
    logic [1:0]    tp;
    cls_e          cn;
    cc_d   = cc_q;
    cls_d  = cls_q;
    tn_d   = tn_q;
    tp_d   = tp_q;
    pok_d  = pok_q;
    num_d  = num_q;
    azt_d  = azt_q;
    aztv_d = aztv_q;
    sp     = (rx_byte_i == CH_SPACE);
    az_line = 1'b0;
    tn     = tn_q;
    tp     = tp_q;
    cn     = cls_q;
    if (rx_byte_i == CH_LF || rx_byte_i == CH_CR) begin
      cc_d   = '0;
      cls_d  = CLS_UNDECIDED;
      tn_d   = TOK_FIRST;
      tp_d   = '0;
      pok_d  = 1'b0;
      num_d  = NUM_CLEAR;
      azt_d  = '0;
      aztv_d = 1'b0;
    end else if (cc_q < LAST) begin
      if (rx_byte_i == CH_NUL) begin
        cc_d = LAST;
      end else begin
        cc_d = cc_q + CW'(1);
        if (cc_q == CW'(0)) begin
          cls_d = (rx_byte_i == CH_A) ? CLS_SAW_A :
                  (rx_byte_i == CH_E) ? CLS_SAW_E : CLS_NONE;
        end else if (cc_q == CW'(1)) begin
          if (cls_q == CLS_SAW_A && rx_byte_i == CH_Z)      cls_d = CLS_AZ;
          else if (cls_q == CLS_SAW_E && rx_byte_i == CH_L) cls_d = CLS_EL;
          else                                              cls_d = CLS_NONE;
        end else begin
          if (cc_q == CW'(2) && cls_q == CLS_AZ && sp)
            cn = CLS_AZ_SPACE;
          else if (cc_q == CW'(3) && cls_q == CLS_AZ_SPACE && rx_byte_i != CH_E)
            cn = CLS_AZ;
          else if (cc_q == CW'(4) && cls_q == CLS_AZ_SPACE)
            cn = (rx_byte_i == CH_L) ? CLS_REPORT : CLS_AZ;
          cls_d   = cn;
          az_line = (cn == CLS_AZ || cn == CLS_AZ_SPACE);
          if (az_line || cn == CLS_EL) begin
            if (tn_q == TOK_FIRST) begin
              if (sp) begin
                if (az_line) begin
                  azt_d  = num_value(num_q);
                  aztv_d = num_q.anum;
                  tn_d   = TOK_GAP;
                  num_d  = NUM_CLEAR;
                end else begin
                  tn_d = TOK_DONE;
                end
              end else begin
                num_d = feed_num(num_q, rx_byte_i);
              end
            end else if (!(tn_q == TOK_GAP && sp)) begin
              if (tn_q == TOK_GAP) begin
                tn = TOK_SECOND;
                tp = '0;
              end
              if (tn == TOK_SECOND) begin
                tn_d = TOK_SECOND;
                tp_d = tp;
                if (sp) begin
                  tn_d = TOK_DONE;
                end else begin
                  if (tp == 2'd0)      pok_d = (rx_byte_i == CH_E);
                  else if (tp == 2'd1) pok_d = pok_q && (rx_byte_i == CH_L);
                  else                 num_d = feed_num(num_q, rx_byte_i);
                  if (tp != 2'd3) tp_d = tp + 2'd1;
                end
              end
            end
          end
        end
      end
    end
  end

  // results of a line terminator
  always_comb begin
    logic              azv;
    logic [15:0]       azval;
    logic              el_ok;
    rclp_pkg::result_t az_r;
    rclp_pkg::result_t el_r;
    out_o = '0;
    azv   = (tn_q == TOK_FIRST) ? num_q.anum : aztv_q;
    azval = (tn_q == TOK_FIRST) ? num_value(num_q) : azt_q;
    el_ok = (tn_q == TOK_SECOND || tn_q == TOK_DONE) && (tp_q >= 2'd2) && pok_q
            && num_q.anum;
    az_r  = '{action: rclp_pkg::ACT_SET_AZ, az: azval, el: '0, last: 1'b0};
    el_r  = '{action: rclp_pkg::ACT_SET_EL, az: '0, el: num_value(num_q), last: 1'b0};
    if (rx_byte_i == CH_LF || rx_byte_i == CH_CR) begin
      if (cls_q == CLS_REPORT) begin
        out_o.cnt    = 2'd1;
        out_o.res[0] = '{action: rclp_pkg::ACT_REPORT, az: az_i, el: el_i, last: 1'b1};
      end else if (cls_q == CLS_AZ || cls_q == CLS_AZ_SPACE) begin
        if (azv && el_ok) begin
          out_o.cnt         = 2'd2;
          out_o.res[0]      = az_r;
          out_o.res[1]      = el_r;
          out_o.res[1].last = 1'b1;
        end else if (azv) begin
          out_o.cnt         = 2'd1;
          out_o.res[0]      = az_r;
          out_o.res[0].last = 1'b1;
        end else if (el_ok) begin
          out_o.cnt         = 2'd1;
          out_o.res[0]      = el_r;
          out_o.res[0].last = 1'b1;
        end
      end else if (cls_q == CLS_EL && num_q.anum) begin
        out_o.cnt         = 2'd1;
        out_o.res[0]      = el_r;
        out_o.res[0].last = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/rclp_queue.sv */
// four-entry result queue taking up to two results per cycle
`default_nettype none

module rclp_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire rclp_pkg::core_out_t push_data_i,
  input  wire logic                pop_i,
  output rclp_pkg::result_t        head_o,
  output rclp_pkg::q_status_t      status_o
);

  localparam int unsigned DEPTH = rclp_pkg::QDepth;
  localparam int unsigned PW    = rclp_pkg::QPtrW;
  localparam int unsigned CNTW  = rclp_pkg::QCntW;

  rclp_pkg::result_t  mem_q [DEPTH];
  logic [PW-1:0]      wr_q, wr_d;
  logic [PW-1:0]      rd_q, rd_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic [1:0]         n_push;

  assign n_push = push_i ? push_data_i.cnt : 2'd0;

  always_comb begin
    wr_d  = wr_q + PW'(n_push);
    rd_d  = rd_q + PW'(pop_i);
    cnt_d = cnt_q + CNTW'(n_push) - CNTW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_q] <= push_data_i.res[0];
    if (n_push == 2'd2) mem_q[wr_q + PW'(1)] <= push_data_i.res[1];
  end

  assign head_o          = mem_q[rd_q];
  assign status_o.count  = cnt_q;
  // room for two more results
  assign status_o.room   = (cnt_q <= CNTW'(DEPTH - 2));

endmodule

`default_nettype wire

/* rtl/rotator_command_line_parser_unit.sv */
// top level of the rotator command line parser
// flow: an accepted request waits in the input register until the queue has room for two results;
//   it is then parsed, and its results are written to the queue and leave it in order
// throughput: one byte per cycle; the queue absorbs a two-result terminator, so the input
//   stalls only when output stalls leave room for fewer than two results
// reset: asynchronous, active low; empties the input stage and queue, restarts the line
`default_nettype none

module rotator_command_line_parser_unit #(
  parameter int unsigned LINE_CHARS = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // byte request channel
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic signed [15:0] current_az_half_i,
  input  wire logic signed [15:0] current_el_half_i,
  // result request channel
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [1:0]         action_o,
  output      logic signed [15:0] azimuth_half_o,
  output      logic signed [15:0] elevation_half_o,
  output      logic               last_of_run_o
);

  // input register stage
  logic                s_valid_q;
  logic [7:0]          s_byte_q;
  logic [15:0]         s_az_q;
  logic [15:0]         s_el_q;

  logic                in_acc;
  logic                fire;
  logic                pop;

  rclp_pkg::core_out_t core_out;
  rclp_pkg::result_t   head;
  rclp_pkg::q_status_t q_status;

  // the staged byte is parsed once the queue can take both of its possible results
  assign fire       = s_valid_q && q_status.room;
  assign in_stall_o = s_valid_q && !q_status.room;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_acc) begin
      s_valid_q <= 1'b1;
    end else if (fire) begin
      s_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_byte_q <= rx_byte_i;
      s_az_q   <= current_az_half_i;
      s_el_q   <= current_el_half_i;
    end
  end

  // line state machine and number accumulator; state advances only on fire
  rclp_core #(
    .LINE_CHARS (LINE_CHARS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .rx_byte_i (s_byte_q),
    .az_i      (s_az_q),
    .el_i      (s_el_q),
    .out_o     (core_out)
  );

  // results wait here so the input side keeps moving under output stall while the queue has room
  rclp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .push_data_i (core_out),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  assign out_valid_o      = (q_status.count != '0);
  assign pop              = out_valid_o && !out_stall_i;
  assign action_o         = head.action;
  assign azimuth_half_o   = head.az;
  assign elevation_half_o = head.el;
  assign last_of_run_o    = head.last;

  // queue never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= rclp_pkg::QCntW'(rclp_pkg::QDepth))
    else $error("result queue overflow");

  // an accepted request is always staged at the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s_valid_q)
    else $error("accepted request lost");

  // output valid drops only after the last entry was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

`default_nettype wire
